// File: hdl/page_table_manager_top_macros.svh
// Assertion macros shared by the page table manager RTL.
// Depends on a clock named clk and a reset named rst in the including module.
`ifndef PAGE_TABLE_MANAGER_TOP_MACROS_SVH
`define PAGE_TABLE_MANAGER_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PTM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PTM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/ptm_pkg.sv
// Types, constants and codes of the page table manager.
// Used by every module of the block; depends on nothing.
package ptm_pkg;

  localparam int PAGE_SIZE    = 4096;
  localparam int PAGE_BITS    = $clog2(PAGE_SIZE);
  localparam int ADDR_W       = 32;
  localparam int VPN_W        = ADDR_W - PAGE_BITS;
  localparam int PROCESSES    = 16;
  localparam int PID_W        = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int ENTRIES      = 128;
  localparam int SLOT_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W        = $clog2(ENTRIES + 1);
  localparam int MEM_AW       = PID_W + SLOT_W;
  localparam int MEM_DEPTH    = PROCESSES << SLOT_W;
  localparam int FRAME_STRIDE = 32'h0010_0000;
  localparam int FRAME_PAGES  = FRAME_STRIDE / PAGE_SIZE;

  localparam logic [2:0] MODE_ALLOC   = 3'd0;
  localparam logic [2:0] MODE_FREE    = 3'd1;
  localparam logic [2:0] MODE_FAULT   = 3'd2;
  localparam logic [2:0] MODE_MAP     = 3'd3;
  localparam logic [2:0] MODE_PROTECT = 3'd4;
  localparam logic [2:0] MODE_XLATE   = 3'd5;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BAD     = 3'd1;
  localparam logic [2:0] ST_ROOM    = 3'd2;
  localparam logic [2:0] ST_ABSENT  = 3'd3;
  localparam logic [2:0] ST_OVERLAP = 3'd4;
  localparam logic [2:0] ST_WDENY   = 3'd5;
  localparam logic [2:0] ST_UDENY   = 3'd6;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  proc_id;
    logic [31:0] virt_addr;
    logic [31:0] byte_count;
    logic [31:0] phys_in;
    logic [1:0]  page_flags;
    logic        is_write;
    logic        is_user;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] phys_out;
  } rsp_t;

  typedef struct packed {
    logic [VPN_W-1:0] vpage;
    logic [VPN_W-1:0] ppage;
    logic [1:0]       flags;
    logic             present;
  } pte_t;

  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] waddr;
    pte_t              wdata;
    logic              re;
    logic [MEM_AW-1:0] raddr;
  } mem_req_t;

  typedef enum logic [1:0] {
    CMP_EQ    = 2'd0,
    CMP_RANGE = 2'd1,
    CMP_SPAN  = 2'd2
  } cmp_op_t;

endpackage

// File: hdl/page_table_manager_top.sv
// Page table manager: takes one command word and returns one response word.
// An accepted command is worked by a sequencer that walks the process's page
// list one entry at a time through a single comparator and an entry memory
// with one write port and one registered read port: each entry is read in
// S_RD and checked in S_CHK, and an allocate then appends its pages in S_APP.
// A process's list holds up to 128 entries.
// Free compacts the list in that same walk. No new command is taken until the
// response is loaded into the output register; a waiting response does not
// block the next command.
// Entry memory needs no clear: only slots below the count are ever read.
// Depends on ptm_pkg, ptm_cmp, ptm_table and page_table_manager_top_macros.svh.
`include "page_table_manager_top_macros.svh"

module page_table_manager_top
  import ptm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  input  logic cmd_valid,
  output logic cmd_stall,
  output rsp_t rsp,
  output logic rsp_valid,
  input  logic rsp_stall
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_START = 6'b000010,
    S_RD    = 6'b000100,
    S_CHK   = 6'b001000,
    S_APP   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t           state;
  cmd_t             cmd_q;
  logic [CNT_W-1:0] counts [PROCESSES];
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] pages_q;
  logic [CNT_W-1:0] iptr;
  logic [CNT_W-1:0] wptr;
  logic [2:0]       status_q;
  logic [31:0]      phys_q;

  mem_req_t         mreq;
  pte_t             rdata;
  cmp_op_t          cop;
  logic             hit;

  logic [PID_W-1:0] pidx;
  logic [CNT_W-1:0] cur_count;
  logic [VPN_W-1:0] va_page;
  logic [VPN_W-1:0] pin_page;
  logic [VPN_W-1:0] fault_ppage;
  logic [31:0]      span_hi;
  logic [32:0]      pages_wide;
  logic             pid_bad;
  logic             va_unal;
  logic             pin_unal;
  logic             room_bad;
  logic             deny_w;
  logic             deny_u;

  assign pidx        = cmd_q.proc_id[PID_W-1:0];
  assign cur_count   = counts[pidx];
  assign va_page     = cmd_q.virt_addr[31:PAGE_BITS];
  assign pin_page    = cmd_q.phys_in[31:PAGE_BITS];
  assign span_hi     = cmd_q.virt_addr + cmd_q.byte_count;
  assign pages_wide  = (33'(cmd_q.byte_count) + 33'(PAGE_SIZE - 1)) >> PAGE_BITS;
  assign pid_bad     = (cmd_q.proc_id == 8'd0) ||
                       ({1'b0, cmd_q.proc_id} >= 9'(PROCESSES)) ||
                       (cmd_q.mode > MODE_XLATE);
  assign va_unal     = (cmd_q.virt_addr[PAGE_BITS-1:0] != '0);
  assign pin_unal    = (cmd_q.phys_in[PAGE_BITS-1:0] != '0);
  assign room_bad    = (pages_wide == 33'd0) ||
                       (33'(cur_count) + pages_wide > 33'(ENTRIES));
  assign fault_ppage = VPN_W'(VPN_W'(cmd_q.proc_id) * VPN_W'(FRAME_PAGES) + VPN_W'(iptr));
  // Write or user access denied by the entry just read
  assign deny_w      = cmd_q.is_write && !rdata.flags[0];
  assign deny_u      = cmd_q.is_user && !rdata.flags[1];

  assign cmd_stall   = (state != S_IDLE);

  // Pick the comparison the walk needs for this command
  always_comb begin
    case (cmd_q.mode)
      MODE_ALLOC: cop = CMP_RANGE;
      MODE_FREE:  cop = CMP_SPAN;
      default:    cop = CMP_EQ;
    endcase
  end

  ptm_cmp u_cmp (
    .op    (cop),
    .epage (rdata.vpage),
    .key   (va_page),
    .span  (pages_q),
    .lo    (cmd_q.virt_addr),
    .hi    (span_hi),
    .hit   (hit)
  );

  ptm_table u_table (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

  // Memory port: reads during the walk, writes for compaction, append and update
  always_comb begin
    logic [CNT_W-1:0] app_slot;
    app_slot   = cnt + wptr;
    mreq       = '0;
    mreq.raddr = {pidx, iptr[SLOT_W-1:0]};
    mreq.waddr = {pidx, iptr[SLOT_W-1:0]};
    mreq.wdata = rdata;
    case (state)
      S_RD: begin
        if (iptr != cnt) begin
          mreq.re = 1'b1;
        end else if (cmd_q.mode == MODE_MAP && cnt < CNT_W'(ENTRIES)) begin
          // Create a new page at the tail
          mreq.we    = 1'b1;
          mreq.waddr = {pidx, cnt[SLOT_W-1:0]};
          mreq.wdata = '{vpage: va_page, ppage: pin_page,
                         flags: cmd_q.page_flags, present: 1'b1};
        end
      end
      S_CHK: begin
        case (cmd_q.mode)
          MODE_FREE: begin
            // Keep the entry: slide it down to the write pointer
            mreq.we    = !hit;
            mreq.waddr = {pidx, wptr[SLOT_W-1:0]};
          end
          MODE_FAULT: begin
            mreq.we            = hit && !deny_w;
            mreq.wdata.ppage   = fault_ppage;
            mreq.wdata.present = 1'b1;
          end
          MODE_MAP: begin
            mreq.we    = hit;
            mreq.wdata = '{vpage: rdata.vpage, ppage: pin_page,
                           flags: cmd_q.page_flags, present: 1'b1};
          end
          MODE_PROTECT: begin
            mreq.we          = hit;
            mreq.wdata.flags = cmd_q.page_flags;
          end
          default: begin
          end
        endcase
      end
      S_APP: begin
        mreq.we    = (wptr != pages_q);
        mreq.waddr = {pidx, app_slot[SLOT_W-1:0]};
        mreq.wdata = '{vpage: va_page + VPN_W'(wptr), ppage: '0,
                       flags: cmd_q.page_flags, present: 1'b0};
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      cmd_q     <= '0;
      for (int p = 0; p < PROCESSES; p++) begin
        counts[p] <= '0;
      end
    end else begin
      // Drop a taken response unless a new one loads this cycle
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_q    <= cmd;
            status_q <= ST_OK;
            phys_q   <= '0;
            state    <= S_START;
          end
        end
        S_START: begin
          cnt  <= cur_count;
          iptr <= '0;
          wptr <= '0;
          pages_q <= pages_wide[CNT_W-1:0];
          if (pid_bad) begin
            status_q <= ST_BAD;
            state    <= S_DONE;
          end else if (cmd_q.mode == MODE_ALLOC && va_unal) begin
            status_q <= ST_BAD;
            state    <= S_DONE;
          end else if (cmd_q.mode == MODE_ALLOC && room_bad) begin
            status_q <= ST_ROOM;
            state    <= S_DONE;
          end else if (cmd_q.mode == MODE_MAP && (va_unal || pin_unal)) begin
            status_q <= ST_BAD;
            state    <= S_DONE;
          end else begin
            state <= S_RD;
          end
        end
        S_RD: begin
          if (iptr != cnt) begin
            state <= S_CHK;
          end else begin
            // Walk finished without an early stop
            case (cmd_q.mode)
              MODE_ALLOC: begin
                state <= S_APP;
              end
              MODE_FREE: begin
                counts[pidx] <= wptr;
                state        <= S_DONE;
              end
              MODE_MAP: begin
                if (cnt < CNT_W'(ENTRIES)) begin
                  counts[pidx] <= cnt + CNT_W'(1);
                end else begin
                  status_q <= ST_ROOM;
                end
                state <= S_DONE;
              end
              default: begin
                status_q <= ST_ABSENT;
                state    <= S_DONE;
              end
            endcase
          end
        end
        S_CHK: begin
          iptr  <= iptr + CNT_W'(1);
          state <= S_RD;
          case (cmd_q.mode)
            MODE_FREE: begin
              if (!hit) begin
                wptr <= wptr + CNT_W'(1);
              end
            end
            MODE_ALLOC: begin
              if (hit) begin
                status_q <= ST_OVERLAP;
                state    <= S_DONE;
              end
            end
            default: begin
              if (hit) begin
                state <= S_DONE;
                if (cmd_q.mode == MODE_FAULT && deny_w) begin
                  status_q <= ST_WDENY;
                end else if (cmd_q.mode == MODE_XLATE) begin
                  if (!rdata.present) begin
                    status_q <= ST_ABSENT;
                  end else if (deny_w) begin
                    status_q <= ST_WDENY;
                  end else if (deny_u) begin
                    status_q <= ST_UDENY;
                  end else begin
                    phys_q <= {rdata.ppage, cmd_q.virt_addr[PAGE_BITS-1:0]};
                  end
                end
              end
            end
          endcase
        end
        S_APP: begin
          if (wptr != pages_q) begin
            wptr <= wptr + CNT_W'(1);
          end else begin
            counts[pidx] <= cnt + pages_q;
            state        <= S_DONE;
          end
        end
        S_DONE: begin
          // Load the output register once it is free
          if (!rsp_valid || !rsp_stall) begin
            rsp.status   <= status_q;
            rsp.phys_out <= phys_q;
            rsp_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PTM_ASSERT(a_busy_after_accept, cmd_valid && !cmd_stall |=> cmd_stall, "accept not busy")
  `PTM_ASSERT(a_count_bound, cur_count <= CNT_W'(ENTRIES), "entry count beyond list size")
  `PTM_ASSERT(a_compact_order, state == S_CHK && cmd_q.mode == MODE_FREE |-> wptr <= iptr, "wptr")
  `PTM_ASSERT(a_phys_zero, rsp_valid && rsp.status != ST_OK |-> rsp.phys_out == 32'd0, "phys")
  `PTM_ASSERT_ALWAYS(a_reset_idle, rst |=> !cmd_stall && !rsp_valid, "not idle after reset")

endmodule

// File: hdl/ptm_table.sv
// Page entry store: one write port, one registered read port.
// Depends on ptm_pkg.
module ptm_table
  import ptm_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output pte_t     rdata
);

  pte_t mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// File: hdl/ptm_cmp.sv
// Shared entry comparator: exact page match, page window, or address span.
// Depends on ptm_pkg.
module ptm_cmp
  import ptm_pkg::*;
(
  input  cmp_op_t          op,
  input  logic [VPN_W-1:0] epage,
  input  logic [VPN_W-1:0] key,
  input  logic [CNT_W-1:0] span,
  input  logic [31:0]      lo,
  input  logic [31:0]      hi,
  output logic             hit
);

  logic [VPN_W-1:0] diff;
  logic [31:0]      eaddr;

  assign diff  = epage - key;
  assign eaddr = {epage, {PAGE_BITS{1'b0}}};

  always_comb begin
    case (op)
      CMP_EQ:    hit = (epage == key);
      CMP_RANGE: hit = (diff < VPN_W'(span));
      CMP_SPAN:  hit = (eaddr >= lo) && (eaddr < hi);
      default:   hit = 1'b0;
    endcase
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of page_table_manager_top: a directed table and
// random commands, each response checked against a typed-in word or a behavioral page table model.
// Depends on ptm_pkg and the page_table_manager_top RTL.
module tb
  import ptm_pkg::*;
;

  localparam int PSZ = 4096;
  localparam int NPROC = 16;
  localparam int NENT = 128;
  localparam int CYCLE_LIMIT = 4000000;
  localparam logic [31:0] STRIDE = 32'h0010_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  cmd_t cmd = '0;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  rsp_t rsp;
  logic rsp_valid;
  logic rsp_stall = 1'b0;

  page_table_manager_top DUT (
    .clk(clk), .rst(rst), .cmd(cmd), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .rsp(rsp), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall)
  );

  always #5 clk = ~clk;

  // Model of the page lists: one ordered list per process.
  logic [31:0] pg_va [NPROC][NENT];
  logic [31:0] pg_pa [NPROC][NENT];
  logic [1:0]  pg_fl [NPROC][NENT];
  logic        pg_pr [NPROC][NENT];
  int          pg_cnt [NPROC];

  rsp_t resp_queue[$];
  int errors = 0;
  int cycles = 0;
  int send_idle = 21;
  int recv_idle = 54;

  // Directed rows: command word, whether an expected response is typed in, and that response.
  typedef struct {
    cmd_t cw;
    bit   known;
    rsp_t want;
  } row_t;

  function automatic int slot_of(int p, logic [31:0] a);
    logic [31:0] b;
    b = a & ~32'(PSZ - 1);
    for (int i = 0; i < pg_cnt[p]; i++) if (pg_va[p][i] == b) return i;
    return -1;
  endfunction

  // Compute the response of one command and update the page lists.
  function automatic rsp_t table_update(cmd_t c);
    rsp_t r;
    int p, s, w;
    logic [32:0] pages;
    logic [31:0] endv;
    r = '0;
    r.status = ST_OK;
    p = c.proc_id;
    if (p == 0 || p >= NPROC || c.mode > MODE_XLATE) begin
      r.status = ST_BAD;
    end else begin
      case (c.mode)
        MODE_ALLOC: begin
          pages = ({1'b0, c.byte_count} + 33'(PSZ - 1)) / PSZ;
          if (c.virt_addr % PSZ != 0) r.status = ST_BAD;
          else if (pages == 0 || pg_cnt[p] + pages > NENT) r.status = ST_ROOM;
          else begin
            for (int i = 0; i < pages; i++)
              if (slot_of(p, c.virt_addr + i * PSZ) >= 0) r.status = ST_OVERLAP;
            if (r.status == ST_OK) begin
              for (int i = 0; i < pages; i++) begin
                s = pg_cnt[p];
                pg_va[p][s] = c.virt_addr + i * PSZ;
                pg_pa[p][s] = '0;
                pg_fl[p][s] = c.page_flags;
                pg_pr[p][s] = 1'b0;
                pg_cnt[p]++;
              end
            end
          end
        end
        MODE_FREE: begin
          endv = c.virt_addr + c.byte_count;
          w = 0;
          for (int i = 0; i < pg_cnt[p]; i++) begin
            if (!(pg_va[p][i] >= c.virt_addr && pg_va[p][i] < endv)) begin
              pg_va[p][w] = pg_va[p][i];
              pg_pa[p][w] = pg_pa[p][i];
              pg_fl[p][w] = pg_fl[p][i];
              pg_pr[p][w] = pg_pr[p][i];
              w++;
            end
          end
          pg_cnt[p] = w;
        end
        MODE_MAP: begin
          if (c.virt_addr % PSZ != 0 || c.phys_in % PSZ != 0) r.status = ST_BAD;
          else begin
            s = slot_of(p, c.virt_addr);
            if (s < 0) begin
              if (pg_cnt[p] >= NENT) r.status = ST_ROOM;
              else begin
                s = pg_cnt[p];
                pg_va[p][s] = c.virt_addr;
                pg_cnt[p]++;
              end
            end
            if (r.status == ST_OK) begin
              pg_pa[p][s] = c.phys_in;
              pg_fl[p][s] = c.page_flags;
              pg_pr[p][s] = 1'b1;
            end
          end
        end
        default: begin
          s = slot_of(p, c.virt_addr);
          if (c.mode == MODE_FAULT) begin
            if (s < 0) r.status = ST_ABSENT;
            else if (c.is_write && !pg_fl[p][s][0]) r.status = ST_WDENY;
            else begin
              pg_pr[p][s] = 1'b1;
              pg_pa[p][s] = 32'(p) * STRIDE + 32'(s) * PSZ;
            end
          end else if (c.mode == MODE_PROTECT) begin
            if (s < 0) r.status = ST_ABSENT;
            else pg_fl[p][s] = c.page_flags;
          end else begin
            if (s < 0 || !pg_pr[p][s]) r.status = ST_ABSENT;
            else if (c.is_write && !pg_fl[p][s][0]) r.status = ST_WDENY;
            else if (c.is_user && !pg_fl[p][s][1]) r.status = ST_UDENY;
            else r.phys_out = pg_pa[p][s] + c.virt_addr % PSZ;
          end
        end
      endcase
    end
    return r;
  endfunction

  function automatic cmd_t mk(logic [2:0] m, logic [7:0] p, logic [31:0] va,
                              logic [31:0] n, logic [31:0] pa, logic [1:0] f,
                              logic wr, logic us);
    cmd_t c;
    c.mode = m; c.proc_id = p; c.virt_addr = va; c.byte_count = n;
    c.phys_in = pa; c.page_flags = f; c.is_write = wr; c.is_user = us;
    return c;
  endfunction

  function automatic rsp_t st(logic [2:0] s, logic [31:0] a);
    rsp_t r;
    r.status = s; r.phys_out = a;
    return r;
  endfunction

  // Pick a page base from a small window, so that commands hit live pages often.
  function automatic logic [31:0] near_page();
    return $urandom_range(0, 1) ? 32'($urandom_range(0, 47)) * PSZ
                                : 32'hFFFF_0000 + 32'($urandom_range(0, 15)) * PSZ;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    c = cmd_t'({$urandom, $urandom, $urandom, $urandom});
    if ($urandom_range(0, 9) == 0) return c;  // noise word, any field value
    c.mode = 3'($urandom_range(0, 5));
    c.proc_id = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(1, 3));
    c.virt_addr = near_page();
    if (c.mode == MODE_FAULT || c.mode == MODE_XLATE || $urandom_range(0, 9) == 0)
      c.virt_addr = c.virt_addr | 32'($urandom_range(0, PSZ - 1));
    c.phys_in = $urandom_range(0, 7) == 0 ? $urandom : ($urandom & ~32'(PSZ - 1));
    if (c.mode == MODE_ALLOC) c.byte_count = $urandom_range(0, 4 * PSZ);
    else if (c.mode == MODE_FREE && $urandom_range(0, 3) != 0)
      c.byte_count = $urandom_range(1, 6 * PSZ);
    return c;
  endfunction

  // Hold the word until the block takes it; record the expected response.
  // Valid drops only while the sender idles or after the last word.
  task automatic send_cmd(cmd_t c, bit known, rsp_t want);
    rsp_t r;
    while ($urandom_range(0, 99) < send_idle) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd <= c;
    cmd_valid <= 1'b1;
    r = table_update(c);
    if (known && r !== want) begin
      $display("%0t directed row predictor mismatch: expected %h actual %h", $time, want, r);
      errors++;
    end
    resp_queue.push_back(known ? want : r);
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
  endtask

  // Receiver: stall at random and check each accepted response word.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (resp_queue.size() == 0) begin
          $display("%0t unexpected response: expected none actual %h", $time, rsp);
          errors++;
        end else begin
          rsp_t want;
          want = resp_queue.pop_front();
          if (rsp.status !== want.status)
            $display("%0t status mismatch: expected %0d actual %0d", $time,
                     want.status, rsp.status);
          if (rsp.phys_out !== want.phys_out)
            $display("%0t phys_out mismatch: expected %h actual %h", $time,
                     want.phys_out, rsp.phys_out);
          if (rsp !== want) errors++;
        end
      end
      rsp_stall <= ($urandom_range(0, 99) < recv_idle);
    end
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  row_t rows[$];

  initial begin
    for (int p = 0; p < NPROC; p++) pg_cnt[p] = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: bad process ids, unused modes, extremes, every status.
    rows.push_back('{mk(MODE_XLATE, 8'd1, 32'h0, 0, 0, 0, 0, 0), 1, st(ST_ABSENT, 0)});
    rows.push_back('{mk(MODE_ALLOC, 8'd0, 32'h0, PSZ, 0, 3, 0, 0), 1, st(ST_BAD, 0)});
    rows.push_back('{mk(MODE_ALLOC, 8'd16, 32'h0, PSZ, 0, 3, 0, 0), 1, st(ST_BAD, 0)});
    rows.push_back('{mk(MODE_ALLOC, 8'd255, 32'h0, PSZ, 0, 3, 1, 1), 1, st(ST_BAD, 0)});
    rows.push_back('{mk(3'd6, 8'd1, 32'h0, 0, 0, 0, 0, 0), 1, st(ST_BAD, 0)});
    rows.push_back('{mk(3'd7, 8'd1, '1, '1, '1, 3, 1, 1), 1, st(ST_BAD, 0)});
    rows.push_back('{mk(MODE_ALLOC, 8'd1, 32'h1, PSZ, 0, 3, 0, 0), 1, st(ST_BAD, 0)});
    rows.push_back('{mk(MODE_ALLOC, 8'd1, 32'h0, 0, 0, 3, 0, 0), 1, st(ST_ROOM, 0)});
    rows.push_back('{mk(MODE_ALLOC, 8'd1, 32'h0, '1, 0, 3, 0, 0), 1, st(ST_ROOM, 0)});
    rows.push_back('{mk(MODE_ALLOC, 8'd1, 32'h0, 3 * PSZ, 0, 1, 0, 0), 1, st(ST_OK, 0)});
    rows.push_back('{mk(MODE_ALLOC, 8'd1, PSZ, PSZ, 0, 1, 0, 0), 1, st(ST_OVERLAP, 0)});
    rows.push_back('{mk(MODE_XLATE, 8'd1, 32'h10, 0, 0, 0, 0, 0), 1, st(ST_ABSENT, 0)});
    rows.push_back('{mk(MODE_FAULT, 8'd1, PSZ + 5, 0, 0, 0, 1, 0), 0, '0});
    rows.push_back('{mk(MODE_XLATE, 8'd1, PSZ + 5, 0, 0, 0, 1, 0), 0, '0});
    rows.push_back('{mk(MODE_XLATE, 8'd1, PSZ + 5, 0, 0, 0, 0, 1), 1, st(ST_UDENY, 0)});
    rows.push_back('{mk(MODE_PROTECT, 8'd1, PSZ, 0, 0, 2, 0, 0), 1, st(ST_OK, 0)});
    rows.push_back('{mk(MODE_XLATE, 8'd1, PSZ, 0, 0, 0, 1, 1), 1, st(ST_WDENY, 0)});
    rows.push_back('{mk(MODE_FAULT, 8'd1, PSZ, 0, 0, 0, 1, 0), 1, st(ST_WDENY, 0)});
    rows.push_back('{mk(MODE_FAULT, 8'd1, 32'h0050_0000, 0, 0, 0, 0, 0), 1, st(ST_ABSENT, 0)});
    rows.push_back('{mk(MODE_PROTECT, 8'd2, 32'h0, 0, 0, 0, 0, 0), 1, st(ST_ABSENT, 0)});
    rows.push_back('{mk(MODE_MAP, 8'd15, 32'hFFFF_F000, 0, 32'h3, 3, 0, 0), 1, st(ST_BAD, 0)});
    rows.push_back('{mk(MODE_MAP, 8'd15, 32'hFFFF_F000, 0, 32'hFFFF_F000, 3, 0, 0),
                     1, st(ST_OK, 0)});
    rows.push_back('{mk(MODE_XLATE, 8'd15, '1, 0, 0, 0, 1, 1), 1, st(ST_OK, '1)});
    // Free with a wrapping end removes nothing.
    rows.push_back('{mk(MODE_FREE, 8'd15, 32'hFFFF_F000, PSZ, 0, 0, 0, 0), 1, st(ST_OK, 0)});
    rows.push_back('{mk(MODE_FREE, 8'd1, 32'h0, PSZ * 2, 0, 0, 0, 0), 1, st(ST_OK, 0)});

    foreach (rows[i]) send_cmd(rows[i].cw, rows[i].known, rows[i].want);

    // Fill one process to its limit and overflow it once.
    send_cmd(mk(MODE_ALLOC, 8'd4, 32'h0, NENT * PSZ, 0, 3, 0, 0), 0, '0);
    send_cmd(mk(MODE_MAP, 8'd4, 32'h0800_0000, 0, 0, 3, 0, 0), 1, st(ST_ROOM, 0));
    send_cmd(mk(MODE_FREE, 8'd4, 32'h0, '1, 0, 0, 0, 0), 0, '0);

    // Random part in three idling phases.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 21 : (ph == 1) ? 54 : 0;
      recv_idle = (ph == 0) ? 54 : (ph == 1) ? 21 : 0;
      for (int i = 0; i < 500; i++) send_cmd(random_cmd(), 0, '0);
    end
    cmd_valid <= 1'b0;

    while (resp_queue.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
